[rtl/sc2a_pkg.sv]
// Shared constants and key table for the scan code to ASCII translator.
`timescale 1ns / 1ps
`default_nettype none

package sc2a_pkg;

  localparam int unsigned TABLE_ROWS = 58;
  localparam int unsigned ROM_ROWS   = 58;
  localparam int unsigned ROW_BITS   = $clog2(ROM_ROWS);

  localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
  localparam logic [7:0] SC_CTRL_BREAK   = 8'h9D;
  localparam logic [7:0] SC_BKSP         = 8'h0E;
  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] SC_CAPS         = 8'h3A;
  localparam logic [7:0] SC_ALT_MAKE     = 8'h38;
  localparam logic [7:0] SC_PREFIX       = 8'hE0;
  localparam logic [7:0] SC_ALT_BREAK    = 8'hB8;
  localparam logic [7:0] SC_F1           = 8'h3B;
  localparam logic [7:0] SC_F3           = 8'h3D;

  localparam logic [2:0] KIND_CHAR   = 3'd0;
  localparam logic [2:0] KIND_BKSP   = 3'd1;
  localparam logic [2:0] KIND_CTRL_L = 3'd2;
  localparam logic [2:0] KIND_ALT_F1 = 3'd3;
  localparam logic [2:0] KIND_ALT_F3 = 3'd5;

  typedef struct packed {
    logic [6:0] base;
    logic [6:0] shifted;
  } key_entry_t;

  // Two-column key table: unshifted and shifted character per row.
  function automatic key_entry_t key_rom(input logic [ROW_BITS-1:0] row);
    key_entry_t e;
    e = '{base: 7'd0, shifted: 7'd0};
    case (row)
      6'd2:  e = '{7'h31, 7'h21};
      6'd3:  e = '{7'h32, 7'h40};
      6'd4:  e = '{7'h33, 7'h23};
      6'd5:  e = '{7'h34, 7'h24};
      6'd6:  e = '{7'h35, 7'h25};
      6'd7:  e = '{7'h36, 7'h5E};
      6'd8:  e = '{7'h37, 7'h26};
      6'd9:  e = '{7'h38, 7'h2A};
      6'd10: e = '{7'h39, 7'h28};
      6'd11: e = '{7'h30, 7'h29};
      6'd12: e = '{7'h2D, 7'h5F};
      6'd13: e = '{7'h3D, 7'h2B};
      6'd16: e = '{7'h71, 7'h51};
      6'd17: e = '{7'h77, 7'h57};
      6'd18: e = '{7'h65, 7'h45};
      6'd19: e = '{7'h72, 7'h52};
      6'd20: e = '{7'h74, 7'h54};
      6'd21: e = '{7'h79, 7'h59};
      6'd22: e = '{7'h75, 7'h55};
      6'd23: e = '{7'h69, 7'h49};
      6'd24: e = '{7'h6F, 7'h4F};
      6'd25: e = '{7'h70, 7'h50};
      6'd26: e = '{7'h5B, 7'h7B};
      6'd27: e = '{7'h5D, 7'h7D};
      6'd28: e = '{7'h0A, 7'h0A};
      6'd30: e = '{7'h61, 7'h41};
      6'd31: e = '{7'h73, 7'h53};
      6'd32: e = '{7'h64, 7'h44};
      6'd33: e = '{7'h66, 7'h46};
      6'd34: e = '{7'h67, 7'h47};
      6'd35: e = '{7'h68, 7'h48};
      6'd36: e = '{7'h6A, 7'h4A};
      6'd37: e = '{7'h6B, 7'h4B};
      6'd38: e = '{7'h6C, 7'h4C};
      6'd39: e = '{7'h3B, 7'h3A};
      6'd40: e = '{7'h27, 7'h22};
      6'd41: e = '{7'h60, 7'h7E};
      6'd43: e = '{7'h5C, 7'h7C};
      6'd44: e = '{7'h7A, 7'h5A};
      6'd45: e = '{7'h78, 7'h58};
      6'd46: e = '{7'h63, 7'h43};
      6'd47: e = '{7'h76, 7'h56};
      6'd48: e = '{7'h62, 7'h42};
      6'd49: e = '{7'h6E, 7'h4E};
      6'd50: e = '{7'h6D, 7'h4D};
      6'd51: e = '{7'h2C, 7'h3C};
      6'd52: e = '{7'h2E, 7'h3E};
      6'd53: e = '{7'h2F, 7'h3F};
      6'd55: e = '{7'h2A, 7'h00};
      6'd57: e = '{7'h20, 7'h20};
      default: e = '{7'h00, 7'h00};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

[rtl/scancode_to_ascii_translator.sv]
// Scan code set 1 to ASCII translator: modifier tracking, key lookup, output register.
//
// Usage: raw keyboard bytes enter on in_valid/in_ready/scan_byte; translated
// items leave on out_valid/out_ready with kind and char_code. A byte that
// maps to nothing (modifiers, prefix, break codes, empty keys) yields no item.
// Path: an accepted byte sits in the input register, is looked up there and
// its result lands in the output register, from which its item is offered.
// Throughput: one byte per cycle while the output drains.
// The limit is the single output register: a byte with a result leaves the
// input register only when that register is free or being emptied.
// Stall: while out_ready is low the output holds; one more byte can still be
// accepted into the input register, after which in_ready drops until the
// output is taken (a byte with no result passes through regardless).
// Reset: rst clears both valid flags and the ctrl, shift, caps lock, alt and
// prefix flags; the block accepts a byte in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module scancode_to_ascii_translator (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] scan_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      kind,
  output logic [6:0]      char_code
);
  import sc2a_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;

  logic ctrl_held, shift_held, caps_active, alt_held, prefix_pending;
  logic ctrl_held_next, shift_held_next, caps_active_next, alt_held_next;
  logic prefix_pending_next;

  logic       res_emit;
  logic [2:0] res_kind;
  logic [6:0] res_char;
  logic       s1_adv;

  key_entry_t entry;
  logic       letter;
  logic [6:0] key;

  always_comb begin
    ctrl_held_next      = ctrl_held;
    shift_held_next     = shift_held;
    caps_active_next    = caps_active;
    alt_held_next       = alt_held;
    prefix_pending_next = prefix_pending;
    res_emit = 1'b0;
    res_kind = KIND_CHAR;
    res_char = 7'd0;
    entry  = key_rom(s1_byte[ROW_BITS-1:0]);
    letter = entry.base inside {[7'h61:7'h7A]};
    key    = entry.base;

    if (prefix_pending) begin
      // byte after 0xE0 only moves alt (right alt)
      prefix_pending_next = 1'b0;
      if (s1_byte == SC_ALT_MAKE) alt_held_next = 1'b1;
      if (s1_byte == SC_ALT_BREAK) alt_held_next = 1'b0;
    end else begin
      if (s1_byte == SC_CTRL_MAKE) ctrl_held_next = 1'b1;
      if (s1_byte == SC_CTRL_BREAK) ctrl_held_next = 1'b0;
      if (s1_byte == SC_CAPS) caps_active_next = !caps_active;
      if (s1_byte == SC_LSHIFT_MAKE || s1_byte == SC_RSHIFT_MAKE) shift_held_next = 1'b1;
      if (s1_byte == SC_LSHIFT_BREAK || s1_byte == SC_RSHIFT_BREAK) shift_held_next = 1'b0;
      if (s1_byte == SC_ALT_MAKE) alt_held_next = 1'b1;
      if (s1_byte == SC_ALT_BREAK) alt_held_next = 1'b0;

      if (caps_active_next && !shift_held_next) begin
        key = letter ? entry.shifted : entry.base;
      end else if (shift_held_next && !caps_active_next) begin
        key = entry.shifted;
      end else if (shift_held_next && caps_active_next) begin
        key = letter ? entry.base : entry.shifted;
      end

      if (s1_byte == SC_PREFIX) begin
        prefix_pending_next = 1'b1;
      end else if (alt_held_next && s1_byte >= SC_F1 && s1_byte <= SC_F3) begin
        res_emit = 1'b1;
        res_kind = 3'(KIND_ALT_F1 + (s1_byte - SC_F1));
      end else if (s1_byte < 8'(TABLE_ROWS) && s1_byte < 8'(ROM_ROWS)) begin
        if (s1_byte == SC_BKSP) begin
          res_emit = 1'b1;
          res_kind = KIND_BKSP;
        end else if (entry.base == 7'h6C && ctrl_held_next) begin
          res_emit = 1'b1;
          res_kind = KIND_CTRL_L;
        end else if (key != 7'd0) begin
          res_emit = 1'b1;
          res_char = key;
        end
      end
    end
  end

  // a byte with no result never waits on the output side
  assign s1_adv   = s1_valid && (!res_emit || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      ctrl_held      <= 1'b0;
      shift_held     <= 1'b0;
      caps_active    <= 1'b0;
      alt_held       <= 1'b0;
      prefix_pending <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv) begin
        ctrl_held      <= ctrl_held_next;
        shift_held     <= shift_held_next;
        caps_active    <= caps_active_next;
        alt_held       <= alt_held_next;
        prefix_pending <= prefix_pending_next;
      end

      if (s1_adv && res_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= scan_byte;
    end
    if (s1_adv && res_emit) begin
      kind      <= res_kind;
      char_code <= res_char;
    end
  end

`ifndef SYNTH
  a_char_only_for_char_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_CHAR |-> char_code == 7'd0)
    else $error("char_code nonzero for a special kind");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind <= KIND_ALT_F3)
    else $error("kind out of range");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    s1_valid && res_emit && out_valid && !out_ready |=> s1_valid && $stable(s1_byte))
    else $error("pending byte lost while output stalled");

  a_prefix_consumed: assert property (@(posedge clk) disable iff (rst)
    prefix_pending && s1_adv |=> !prefix_pending)
    else $error("prefix flag not cleared by following byte");
`endif

endmodule

`default_nettype wire

[sim/scan_translate_checker.sv]
// Checker for the scan code translator: tracks modifier state, predicts and compares items.
`timescale 1ns / 1ps

module scan_translate_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] scan_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] kind,
  input  logic [6:0] char_code,
  output int         mismatches,
  output int         keys_waiting,
  output int         bytes_taken,
  output int         keys_checked
);
  import sc2a_pkg::*;

  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] ch;
  } key_out_t;

  // unshifted and shifted character per scan code row
  logic [6:0] plain_tab [58] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h00, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };
  logic [6:0] shift_tab [58] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00, 7'h00, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00, 7'h00, 7'h20
  };

  bit ctrl_on, shift_down, caps_on, alt_on, e0_seen;
  key_out_t expected_keys [$];

  // Updates the modifier flags for one byte; returns 1 when an item comes out.
  function automatic bit translate_scan(input logic [7:0] sc, output key_out_t k);
    logic [7:0] fkey_off;
    logic [6:0] lo, hi, pick;
    bit         letter;
    k = '0;
    if (e0_seen) begin
      // byte after the prefix only touches alt
      e0_seen = 1'b0;
      if (sc == SC_ALT_MAKE) alt_on = 1'b1;
      if (sc == SC_ALT_BREAK) alt_on = 1'b0;
      return 1'b0;
    end
    case (sc)
      SC_CTRL_MAKE:                     ctrl_on = 1'b1;
      SC_CTRL_BREAK:                    ctrl_on = 1'b0;
      SC_CAPS:                          caps_on = !caps_on;
      SC_LSHIFT_MAKE, SC_RSHIFT_MAKE:   shift_down = 1'b1;
      SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: shift_down = 1'b0;
      SC_ALT_MAKE:                      alt_on = 1'b1;
      SC_ALT_BREAK:                     alt_on = 1'b0;
      SC_PREFIX: begin
        e0_seen = 1'b1;
        return 1'b0;
      end
      default: ;
    endcase
    if (alt_on && sc >= SC_F1 && sc <= SC_F3) begin
      fkey_off = sc - SC_F1;
      k.kind = KIND_ALT_F1 + fkey_off[2:0];
      return 1'b1;
    end
    if (sc >= TABLE_ROWS) return 1'b0;
    if (sc == SC_BKSP) begin
      k.kind = KIND_BKSP;
      return 1'b1;
    end
    lo = plain_tab[sc[5:0]];
    hi = shift_tab[sc[5:0]];
    if (ctrl_on && lo == 7'h6C) begin  // lowercase l
      k.kind = KIND_CTRL_L;
      return 1'b1;
    end
    letter = lo >= 7'h61 && lo <= 7'h7A;
    // caps flips letters, shift flips everything, both together flip non-letters
    pick = ((caps_on && letter) != shift_down) ? hi : lo;
    if (pick == 7'h00) return 1'b0;
    k.kind = KIND_CHAR;
    k.ch   = pick;
    return 1'b1;
  endfunction

  task automatic report_miss(input string what, input key_out_t want, input key_out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: expected kind %0d char %h, got kind %0d char %h",
               $time, what, want.kind, want.ch, got.kind, got.ch);
  endtask

  always @(posedge clk) begin : watch
    key_out_t want, got;
    if (rst) begin
      ctrl_on      = 1'b0;
      shift_down   = 1'b0;
      caps_on      = 1'b0;
      alt_on       = 1'b0;
      e0_seen      = 1'b0;
      mismatches   = 0;
      bytes_taken  = 0;
      keys_checked = 0;
      expected_keys.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.kind = kind;
        got.ch   = char_code;
        keys_checked++;
        if (expected_keys.size() == 0) begin
          report_miss("unexpected item", '0, got);
        end else begin
          want = expected_keys.pop_front();
          if (want.kind != got.kind || want.ch != got.ch)
            report_miss("wrong item", want, got);
        end
      end
      if (in_valid && in_ready) begin
        bytes_taken++;
        if (translate_scan(scan_byte, want)) expected_keys.push_back(want);
      end
    end
    keys_waiting = expected_keys.size();
  end

endmodule

[sim/scancode_to_ascii_translator_tb.sv]
// Testbench top for the scan code translator: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module scancode_to_ascii_translator_tb;
  import sc2a_pkg::*;

  localparam int         CYCLE_LIMIT = 200000;
  localparam int         RANDOM_KEYS = 560;
  localparam int         HOLD_CYCLES = 120;
  localparam logic [7:0] SC_L        = 8'h26;
  localparam logic [7:0] BREAK_BIT   = 8'h80;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       out_ready = 1'b0;
  logic [7:0] scan_byte = 8'h00;
  logic       in_ready, out_valid;
  logic [2:0] kind;
  logic [6:0] char_code;

  int mismatches, keys_waiting, bytes_taken, keys_checked;
  int cycle_count = 0;
  bit send_gaps = 1'b1;
  bit recv_stalls = 1'b1;
  int hold_reqs = 0;

  // corner cases: empty row, caps/shift combos, shifted keypad star, backspace,
  // ctrl-L, last row, out of range, prefixed alt, alt F-keys, double prefix
  logic [7:0] directed_bytes [26] = '{
    8'h00, 8'h1E, 8'h3A, 8'h1E, 8'h02, 8'h2A, 8'h1E, 8'h02, 8'h3A, 8'h37,
    8'hAA, 8'h37, 8'h0E, 8'h1D, 8'h26, 8'h9D, 8'h39, 8'hFF, 8'hE0, 8'h38,
    8'h3B, 8'h3C, 8'h3D, 8'hE0, 8'hE0, 8'hB8
  };

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  scancode_to_ascii_translator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .scan_byte (scan_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .char_code (char_code)
  );

  scan_translate_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .scan_byte    (scan_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .char_code    (char_code),
    .mismatches   (mismatches),
    .keys_waiting (keys_waiting),
    .bytes_taken  (bytes_taken),
    .keys_checked (keys_checked)
  );

  task automatic send_byte(input logic [7:0] b);
    while (send_gaps && $urandom_range(0, 99) < 37) begin
      in_valid  <= 1'b0;
      scan_byte <= 8'($urandom_range(0, 255));
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    scan_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering until every predicted item has been taken
  task automatic drain_keys();
    in_valid <= 1'b0;
    do @(negedge clk); while (keys_waiting != 0);
    @(posedge clk);
  endtask

  initial begin : receiver
    int n;
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs > holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        out_ready <= !(recv_stalls && $urandom_range(0, 99) < 37);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d items still due", cycle_count, keys_waiting);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int         picked;
    int         effective;
    logic [7:0] code;
    bit         hold_done;
    bit         drained;
    hold_done = 1'b0;
    drained   = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    effective = 0;
    while (effective < RANDOM_KEYS) begin
      // a long stretch with both sides streaming
      send_gaps   = !(effective >= 200 && effective < 290);
      recv_stalls = send_gaps;
      if (effective >= 100 && !hold_done) begin
        hold_done = 1'b1;
        hold_reqs++;
      end
      if (effective >= 380 && !drained) begin
        drained = 1'b1;
        drain_keys();
      end
      picked = $urandom_range(0, 99);
      if (picked < 45) begin
        code = ($urandom_range(0, 9) == 0) ? SC_L : 8'($urandom_range(0, TABLE_ROWS - 1));
        send_byte(code);
        if ($urandom_range(0, 1)) send_byte(code | BREAK_BIT);
        effective++;
      end else if (picked < 60) begin
        code = $urandom_range(0, 1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE;
        send_byte($urandom_range(0, 1) ? code : (code | BREAK_BIT));
        effective++;
      end else if (picked < 65) begin
        send_byte(SC_CAPS);
        if ($urandom_range(0, 1)) send_byte(SC_CAPS | BREAK_BIT);
        effective++;
      end else if (picked < 73) begin
        send_byte($urandom_range(0, 1) ? SC_CTRL_MAKE : SC_CTRL_BREAK);
        effective++;
      end else if (picked < 83) begin
        if ($urandom_range(0, 1)) send_byte(SC_PREFIX);
        send_byte($urandom_range(0, 1) ? SC_ALT_MAKE : SC_ALT_BREAK);
        effective++;
      end else if (picked < 90) begin
        send_byte(SC_F1 + 8'($urandom_range(0, 2)));
        effective++;
      end else begin
        // noise: raw bytes, sometimes behind a prefix
        if ($urandom_range(0, 2) == 0) send_byte(SC_PREFIX);
        send_byte(8'($urandom_range(0, 255)));
      end
    end

    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    drain_keys();
    repeat (6) @(posedge clk);

    $display("Covered %0d scan bytes: corner cases, modifier and prefix sequences, noise,",
             bytes_taken);
    $display("and %0d translated items under random, streaming and held-off flow.",
             keys_checked);
    if (mismatches == 0 && keys_waiting == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
